// ----- hw/rtl/glqr_pkg.sv -----
// ----------------------------------------------------------------------------
// glqr_pkg
// Shared payload types and the fixed gain coefficient table, in millionths.
// ----------------------------------------------------------------------------
`default_nettype none
package glqr_pkg;

  localparam int W = 32;
  localparam int ROWS = 12;
  localparam int TERMS = 6;

  typedef struct packed {
    logic signed [W-1:0] leg_length;
    logic signed [W-1:0] leg_angle;
    logic signed [W-1:0] leg_angle_rate;
    logic signed [W-1:0] target_distance;
    logic signed [W-1:0] measured_distance;
    logic signed [W-1:0] target_speed;
    logic signed [W-1:0] measured_speed;
    logic signed [W-1:0] body_pitch;
    logic signed [W-1:0] body_pitch_rate;
  } in_item_t;

  typedef struct packed {
    logic signed [W-1:0] wheel_torque;
    logic signed [W-1:0] hip_torque;
  } out_item_t;

  // Coefficient in millionths: c2, c1, c0 for a row.
  function automatic logic signed [31:0] coef_micro(input int row, input int k);
    logic signed [31:0] t [ROWS][3];
    t = '{
      '{ 32'sd69702762, -32'sd142040660, -32'sd4207897},
      '{-32'sd7339029, -32'sd23447057, 32'sd722030},
      '{ 32'sd33081397, -32'sd27904707, -32'sd13116724},
      '{ 32'sd27721428, -32'sd32372076, -32'sd8152221},
      '{ 32'sd153974674, -32'sd146805480, 32'sd46407912},
      '{ 32'sd5255443, -32'sd5274444, 32'sd1490716},
      '{ 32'sd1448103, -32'sd10394075, 32'sd20866157},
      '{-32'sd5077549, 32'sd6145159, 32'sd2063441},
      '{ 32'sd73286899, -32'sd72417205, 32'sd24880666},
      '{ 32'sd43401631, -32'sd44053902, 32'sd17217584},
      '{-32'sd122870625, 32'sd101478137, 32'sd107736492},
      '{-32'sd3391576, 32'sd2711421, 32'sd2517693}
    };
    return t[row][k];
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/gain_scheduled_lqr_torque_core.sv -----
// ----------------------------------------------------------------------------
// gain_scheduled_lqr_torque_core
// Leg-length scheduled LQR feedback: twelve quadratic gains times six state
// terms, summed into wheel and hip torque, saturated fixed point.
// ----------------------------------------------------------------------------
// The done strobe follows an accepted start through the stages listed below.
// Throughput: one transaction per cycle; busy is always low.
// Stages: square and state terms, length products, square products and rounded
// linear part, gain sum, gain*term products, rounded total with saturation.
// Reset clears only the stage valid bits; data registers are not reset.
`default_nettype none
module gain_scheduled_lqr_torque_core #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire glqr_pkg::in_item_t   in_item,
  output logic                      done,
  output glqr_pkg::out_item_t       result
);

  localparam int DATA_WIDTH = glqr_pkg::W;
  localparam int RW = 9 + FRAC_BITS + 1;        // coefficient width
  localparam int PW = 2 * DATA_WIDTH + 2;       // product width
  localparam int NR = glqr_pkg::ROWS;
  localparam int NT = glqr_pkg::TERMS;
  localparam int SW = DATA_WIDTH + 4;           // wide sum width
  localparam logic signed [SW-1:0] WMAX = SW'((64'sd1 <<< (DATA_WIDTH-1)) - 1);
  localparam logic signed [SW-1:0] WMIN = -SW'(64'sd1 <<< (DATA_WIDTH-1));

  typedef logic signed [DATA_WIDTH-1:0] word_t;
  typedef logic signed [RW-1:0] coef_t;

  // Coefficient in fixed point, round half away from zero (elaboration only).
  function automatic coef_t cfix(input int row, input int k);
    longint m;
    longint q;
    m = longint'(glqr_pkg::coef_micro(row, k));
    q = (((m < 0) ? -m : m) * (longint'(1) << FRAC_BITS) + 500000) / 1000000;
    return coef_t'((m < 0) ? -q : q);
  endfunction

  function automatic word_t sat(input logic signed [SW-1:0] v);
    if (v > WMAX) return word_t'(WMAX);
    if (v < WMIN) return word_t'(WMIN);
    return word_t'(v);
  endfunction

  // Rounded, sign-magnitude scaled product with saturation.
  function automatic word_t qmul(input logic signed [PW-1:0] p);
    logic [PW-1:0] mag;
    logic [PW-1:0] r;
    logic signed [SW-1:0] s;
    mag = p[PW-1] ? PW'(-p) : PW'(p);
    r = (mag + (PW'(1) << (FRAC_BITS-1))) >> FRAC_BITS;
    if (r > PW'(WMAX) + PW'(1)) r = PW'(WMAX) + PW'(1);
    s = p[PW-1] ? -SW'(r) : SW'(r);
    return sat(s);
  endfunction

  function automatic logic signed [PW-1:0] mulw(input logic signed [RW-1:0] a,
                                                input word_t b);
    return PW'(a) * PW'(b);
  endfunction

  word_t din [9];
  assign din[0] = word_t'(in_item.leg_length);
  assign din[1] = word_t'(in_item.leg_angle);
  assign din[2] = word_t'(in_item.leg_angle_rate);
  assign din[3] = word_t'(in_item.target_distance);
  assign din[4] = word_t'(in_item.measured_distance);
  assign din[5] = word_t'(in_item.target_speed);
  assign din[6] = word_t'(in_item.measured_speed);
  assign din[7] = word_t'(in_item.body_pitch);
  assign din[8] = word_t'(in_item.body_pitch_rate);

  logic [5:0] vld;
  assign busy = 1'b0;

  // Stage 1: length squared product, state terms.
  logic signed [2*DATA_WIDTH-1:0] s1_sq;
  word_t s1_len;
  word_t s1_term [NT];
  // Stage 2: rounded square and the length products.
  word_t s2_sq;
  logic signed [PW-1:0] s2_p1 [NR];
  word_t s2_term [NT];
  // Stage 3: square products, linear part rounded.
  logic signed [PW-1:0] s3_p2 [NR];
  word_t s3_l [NR];
  word_t s3_term [NT];
  // Stage 4: gains.
  word_t s4_g [NR];
  word_t s4_term [NT];
  // Stage 5: gain times term products.
  logic signed [PW-1:0] s5_p [NR];
  // Stage 6: saturated torque.
  glqr_pkg::out_item_t s6;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[4:0], start};
    end
    s1_len <= din[0];
    s1_sq  <= din[0] * din[0];
    s1_term[0] <= sat(-SW'(din[1]));
    s1_term[1] <= sat(-SW'(din[2]));
    s1_term[2] <= sat(SW'(din[3]) - SW'(din[4]));
    s1_term[3] <= sat(SW'(din[5]) - SW'(din[6]));
    s1_term[4] <= sat(-SW'(din[7]));
    s1_term[5] <= sat(-SW'(din[8]));

    s2_sq <= qmul(PW'(s1_sq));
    s2_term <= s1_term;
    for (int r = 0; r < NR; r++) s2_p1[r] <= mulw(cfix(r, 1), s1_len);

    s3_term <= s2_term;
    for (int r = 0; r < NR; r++) begin
      s3_p2[r] <= mulw(cfix(r, 0), s2_sq);
      s3_l[r]  <= qmul(s2_p1[r]);
    end

    s4_term <= s3_term;
    for (int r = 0; r < NR; r++)
      s4_g[r] <= sat(SW'(qmul(s3_p2[r])) + SW'(s3_l[r]) + SW'(cfix(r, 2)));

    for (int r = 0; r < NR; r++) s5_p[r] <= PW'(s4_g[r]) * PW'(s4_term[r % NT]);

    s6.wheel_torque <= glqr_pkg::W'(sat(SW'(qmul(s5_p[0])) + SW'(qmul(s5_p[1]))
      + SW'(qmul(s5_p[2])) + SW'(qmul(s5_p[3])) + SW'(qmul(s5_p[4]))
      + SW'(qmul(s5_p[5]))));
    s6.hip_torque <= glqr_pkg::W'(sat(SW'(qmul(s5_p[6])) + SW'(qmul(s5_p[7]))
      + SW'(qmul(s5_p[8])) + SW'(qmul(s5_p[9])) + SW'(qmul(s5_p[10]))
      + SW'(qmul(s5_p[11]))));
  end

  assign done = vld[5];
  assign result = s6;

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##6 done) else $error("done did not follow start");
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 6)) else $error("done without start");
  a_never_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");

endmodule
`default_nettype wire

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// Testbench for gain_scheduled_lqr_torque_core
// Drives random and corner-case balancer states with random start gaps,
// predicts wheel and hip torque in fixed point and checks every done strobe.
// ----------------------------------------------------------------------------
`default_nettype none

class torque_scoreboard;
  glqr_pkg::out_item_t pending[$];
  int errors;

  function new();
    errors = 0;
  endfunction

  static function longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  static function longint coef_q(int micro);
    longint mag;
    longint q;
    mag = (micro < 0) ? -longint'(micro) : longint'(micro);
    q = ((mag << 16) + 500000) / 1000000;
    return (micro < 0) ? -q : q;
  endfunction

  // Rounded magnitude product, then sign, then saturation.
  static function longint fx_mul(longint a, longint b);
    logic [127:0] ua;
    logic [127:0] ub;
    logic [127:0] p;
    longint r;
    bit neg;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? 128'(-a) : 128'(a);
    ub = (b < 0) ? 128'(-b) : 128'(b);
    p = (ua * ub + 128'd32768) >> 16;
    if (p > 128'h8000_0000) p = 128'h8000_0000;
    r = longint'(p[63:0]);
    return sat32(neg ? -r : r);
  endfunction

  function void note_input(glqr_pkg::in_item_t it);
    longint len;
    longint lsq;
    longint g;
    longint acc;
    longint terms[6];
    glqr_pkg::out_item_t exp_item;
    len = longint'(it.leg_length);
    lsq = fx_mul(len, len);
    terms[0] = sat32(-longint'(it.leg_angle));
    terms[1] = sat32(-longint'(it.leg_angle_rate));
    terms[2] = sat32(longint'(it.target_distance) - longint'(it.measured_distance));
    terms[3] = sat32(longint'(it.target_speed) - longint'(it.measured_speed));
    terms[4] = sat32(-longint'(it.body_pitch));
    terms[5] = sat32(-longint'(it.body_pitch_rate));
    for (int o = 0; o < 2; o++) begin
      acc = 0;
      for (int r = 0; r < glqr_pkg::TERMS; r++) begin
        g = fx_mul(coef_q(glqr_pkg::coef_micro(o * 6 + r, 0)), lsq)
          + fx_mul(coef_q(glqr_pkg::coef_micro(o * 6 + r, 1)), len)
          + coef_q(glqr_pkg::coef_micro(o * 6 + r, 2));
        acc += fx_mul(sat32(g), terms[r]);
      end
      if (o == 0) exp_item.wheel_torque = 32'(sat32(acc));
      else exp_item.hip_torque = 32'(sat32(acc));
    end
    pending.push_back(exp_item);
  endfunction

  function void check_result(glqr_pkg::out_item_t got);
    glqr_pkg::out_item_t e;
    if (pending.size() == 0) begin
      $error("result with no transaction outstanding");
      errors++;
      return;
    end
    e = pending.pop_front();
    if (got.wheel_torque !== e.wheel_torque) begin
      $error("wheel_torque expected %0d actual %0d", e.wheel_torque, got.wheel_torque);
      errors++;
    end
    if (got.hip_torque !== e.hip_torque) begin
      $error("hip_torque expected %0d actual %0d", e.hip_torque, got.hip_torque);
      errors++;
    end
  endfunction
endclass

module tb;
  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic done;
  glqr_pkg::in_item_t in_item;
  glqr_pkg::out_item_t result;
  torque_scoreboard sb;

  gain_scheduled_lqr_torque_core u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .in_item(in_item), .done(done), .result(result)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(int'($urandom_range(0, 131072)) - 65536);
      3: return 32'(int'($urandom_range(0, 2000000)) - 1000000);
      4: return 32'(int'($urandom_range(0, 40000)) - 20000);
      default: return $urandom();
    endcase
  endfunction

  // Leg lengths mostly in a physical range, sometimes anywhere.
  function automatic logic [31:0] pick_length();
    if ($urandom_range(0, 3) == 0) return pick_value();
    return 32'($urandom_range(0, 40000) + 3000);
  endfunction

  task automatic send_item(glqr_pkg::in_item_t it, bit may_idle);
    if (may_idle) begin
      while ($urandom_range(0, 99) < 9) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_input(it);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    glqr_pkg::in_item_t it;
    logic [31:0] corners[6];
    sb = new();
    rst <= 1'b1;
    start <= 1'b0;
    in_item <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    corners = '{32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h0001_0000,
                32'hffff_0000};
    for (int k = 0; k < 6; k++) begin
      it = {9{corners[k]}};
      send_item(it, 1'b0);
    end
    // Most negative angles and pitches, and differences that overflow both ways.
    it = '0;
    it.leg_length = 32'h0000_3000;
    it.leg_angle = 32'h8000_0000;
    it.leg_angle_rate = 32'h8000_0000;
    it.body_pitch = 32'h8000_0000;
    it.body_pitch_rate = 32'h8000_0000;
    it.target_distance = 32'h7fff_ffff;
    it.measured_distance = 32'h8000_0000;
    it.target_speed = 32'h8000_0000;
    it.measured_speed = 32'h7fff_ffff;
    send_item(it, 1'b0);
    for (int k = 0; k < 12; k++) begin
      it = {32'(k * 9000), {8{pick_value()}}};
      send_item(it, 1'b0);
    end
    drain();

    for (int n = 0; n < 1550; n++) begin
      it.leg_length = pick_length();
      it.leg_angle = pick_value();
      it.leg_angle_rate = pick_value();
      it.target_distance = pick_value();
      it.measured_distance = pick_value();
      it.target_speed = pick_value();
      it.measured_speed = pick_value();
      it.body_pitch = pick_value();
      it.body_pitch_rate = pick_value();
      send_item(it, !(n >= 400 && n < 700));
      if (n == 1000) drain();
    end
    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS gain_scheduled_lqr_torque_core");
    end else begin
      $display("FAIL gain_scheduled_lqr_torque_core");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL gain_scheduled_lqr_torque_core");
    $finish;
  end
endmodule
`default_nettype wire
